@@ sv/mtl_pkg.sv @@
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared types and constants of the multibit trie longest prefix match table.
// ----------------------------------------------------------------------------
package mtl_pkg;

    localparam int STRIDE_BITS  = 4;
    localparam int CHILD_FANOUT = 1 << STRIDE_BITS;
    localparam int SLOT_FANOUT  = CHILD_FANOUT - 1;
    localparam int ADDR_BITS    = 32;
    localparam int LEVEL_MAX    = ADDR_BITS / STRIDE_BITS;
    localparam int LEVEL_W      = 4;
    localparam int SLOT_IDX_W   = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_DELETE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] next_hop_in;
        logic [3:0]  iface_in;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] next_hop_out;
        logic [3:0]  iface_out;
        logic [5:0]  match_len;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] hop;
        logic [3:0]  iface;
    } slot_t;

    typedef slot_t [SLOT_FANOUT-1:0] slot_row_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    rd;
        logic    lk_eval;
        logic    descend;
        logic    alloc;
        logic    slot_wr;
        logic    finish;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_lookup;
        logic is_insert;
        logic is_delete;
        logic len_bad;
        logic at_target;
        logic child_zero;
        logic lk_stop;
        logic slot_hit;
        logic pool_short;
        logic alloc_last;
        logic out_busy;
    } stat_t;

    // Slot of a route with length offset r whose next bits are top (MSB first).
    function automatic logic [SLOT_IDX_W-1:0] slot_index(input logic [1:0] r,
                                                         input logic [2:0] top);
        logic [SLOT_IDX_W-1:0] idx;
        case (r)
            2'd0:    idx = 4'd0;
            2'd1:    idx = 4'd1 + {3'd0, top[2]};
            2'd2:    idx = 4'd3 + {2'd0, top[2:1]};
            2'd3:    idx = 4'd7 + {1'd0, top};
            default: idx = 4'd0;
        endcase
        return idx;
    endfunction

endpackage

@@ sv/multibit_trie_lpm_table_top.sv @@
// ----------------------------------------------------------------------------
// multibit_trie_lpm_table_top
// IPv4 route table with insert, exact search, longest prefix lookup, delete.
// ----------------------------------------------------------------------------
// After reset the block clears its node memories one node at a time and
// takes no request word until that pass ends. Each node visit is a
// registered read of the node's child row and route row, followed by a step
// that examines it. An insert that creates nodes adds an allocation step per
// new node, and an insert, or a delete that finds its route, adds one write
// step. The dependent child read at each trie level sets the pace of the walk.
// A new request word is accepted while the previous response word still
// waits.
module multibit_trie_lpm_table_top #(
    parameter int NODE_COUNT  = 1024,
    parameter int IFACE_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mtl_pkg::req_t  req_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mtl_pkg::rsp_t  rsp_word
);
    import mtl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mtl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtl_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .IFACE_COUNT (IFACE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.rd, cmd.lk_eval, cmd.descend,
                  cmd.alloc, cmd.slot_wr, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    a_alloc_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !stat.at_target && stat.is_insert)
        else $error("node allocated outside an insert walk");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !stat.out_busy)
        else $error("response word overwritten while stalled");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid)
        else $error("finished operation gave no response word");

endmodule

@@ sv/mtl_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtl_ctrl
// Sequencer of the trie table: clearing pass, trie walk, allocation, writes.
// ----------------------------------------------------------------------------
module mtl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mtl_pkg::stat_t stat,
    output mtl_pkg::cmd_t  cmd
);
    import mtl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_ALLOC,
        S_WRITE,
        S_RESP
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.len_bad)
                begin
                    code_next  = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.is_lookup)
                begin
                    cmd.lk_eval = 1'b1;
                    state_next  = stat.lk_stop ? S_RESP : S_READ;
                end
                else if (!stat.at_target)
                begin
                    if (!stat.child_zero)
                    begin
                        cmd.descend = 1'b1;
                        state_next  = S_READ;
                    end
                    else if (stat.is_insert && !stat.pool_short)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        code_next  = stat.is_insert ? ST_FULL : ST_NOT_FOUND;
                        state_next = S_RESP;
                    end
                end
                else if (stat.is_insert || (stat.is_delete && stat.slot_hit))
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    code_next  = stat.slot_hit ? ST_DONE : ST_NOT_FOUND;
                    state_next = S_RESP;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc = 1'b1;
                if (stat.alloc_last)
                begin
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                cmd.slot_wr = 1'b1;
                code_next   = ST_DONE;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

@@ sv/mtl_dp.sv @@
// ----------------------------------------------------------------------------
// mtl_dp
// Datapath of the trie table: node memories, walk registers, output word.
// ----------------------------------------------------------------------------
module mtl_dp #(
    parameter int NODE_COUNT  = 1024,
    parameter int IFACE_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mtl_pkg::req_t  req_word,
    input  mtl_pkg::cmd_t  cmd,
    output mtl_pkg::stat_t stat,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mtl_pkg::rsp_t  rsp_word
);
    import mtl_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam logic [NODE_W:0] NODE_TOTAL = (NODE_W + 1)'(NODE_COUNT);
    localparam logic [NODE_W-1:0] CLEAR_END = NODE_W'(NODE_COUNT - 1);

    typedef logic [NODE_W-1:0] node_id_t;
    typedef node_id_t [CHILD_FANOUT-1:0] child_row_t;

    child_row_t child_mem [NODE_COUNT];
    slot_row_t  slot_mem  [NODE_COUNT];

    child_row_t child_rd_reg;
    slot_row_t  slot_rd_reg;

    opcode_t            op_reg;
    logic [31:0]        addr_sh_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [1:0]         r_reg;
    logic               len_bad_reg;
    logic [31:0]        hop_reg;
    logic [3:0]         ifc_reg;
    node_id_t           node_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               fresh_reg;
    logic [NODE_W:0]    niu_reg;
    node_id_t           clr_idx_reg;
    logic               best_hit_reg, best_hit_next;
    logic [31:0]        best_hop_reg, best_hop_next;
    logic [3:0]         best_ifc_reg, best_ifc_next;
    logic [5:0]         best_len_reg, best_len_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg, rsp_next;

    logic [3:0]            nib;
    node_id_t              child;
    logic                  last_level;
    logic [SLOT_IDX_W-1:0] tgt_idx;
    logic [LEVEL_W-1:0]    missing;
    logic [NODE_W:0]       free_nodes;
    child_row_t            alloc_row;
    slot_row_t             wr_row;

    // Interface ids are stored reduced modulo the interface count.
    function automatic logic [3:0] iface_wrap(input logic [3:0] v);
        logic [8:0] x;
        x = {5'd0, v};
        for (int k = 0; k < 8; k++)
        begin
            if (x >= 9'(IFACE_COUNT))
            begin
                x = x - 9'(IFACE_COUNT);
            end
        end
        return x[3:0];
    endfunction

    assign nib        = addr_sh_reg[31:28];
    assign child      = child_rd_reg[nib];
    assign last_level = (level_reg == LEVEL_W'(LEVEL_MAX));
    assign tgt_idx    = slot_index(r_reg, addr_sh_reg[31:29]);
    assign missing    = q_reg - level_reg;
    assign free_nodes = NODE_TOTAL - niu_reg;

    always_comb
    begin
        stat            = '0;
        stat.clear_last = (clr_idx_reg == CLEAR_END);
        stat.is_lookup  = (op_reg == OP_LOOKUP);
        stat.is_insert  = (op_reg == OP_INSERT);
        stat.is_delete  = (op_reg == OP_DELETE);
        stat.len_bad    = len_bad_reg;
        stat.at_target  = (level_reg == q_reg);
        stat.child_zero = (child == '0);
        stat.lk_stop    = last_level || (child == '0);
        stat.slot_hit   = slot_rd_reg[tgt_idx].valid;
        stat.pool_short = ((NODE_W + 1)'(missing) > free_nodes);
        stat.alloc_last = ((level_reg + 1'b1) == q_reg);
        stat.out_busy   = rsp_valid_reg && rsp_stall;
    end

    // Longer offsets at the same node, and deeper nodes, override shorter matches.
    always_comb
    begin
        best_hit_next = best_hit_reg;
        best_hop_next = best_hop_reg;
        best_ifc_next = best_ifc_reg;
        best_len_next = best_len_reg;
        for (int r = 0; r < 4; r++)
        begin
            if (((r == 0) || !last_level) &&
                slot_rd_reg[slot_index(2'(r), addr_sh_reg[31:29])].valid)
            begin
                best_hit_next = 1'b1;
                best_hop_next = slot_rd_reg[slot_index(2'(r), addr_sh_reg[31:29])].hop;
                best_ifc_next = slot_rd_reg[slot_index(2'(r), addr_sh_reg[31:29])].iface;
                best_len_next = {level_reg, 2'(r)};
            end
        end
    end

    always_comb
    begin
        alloc_row      = fresh_reg ? '0 : child_rd_reg;
        alloc_row[nib] = niu_reg[NODE_W-1:0];
        wr_row         = slot_rd_reg;
        if (op_reg == OP_INSERT)
        begin
            wr_row[tgt_idx] = '{valid: 1'b1, hop: hop_reg, iface: ifc_reg};
        end
        else
        begin
            wr_row[tgt_idx] = '0;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (op_reg == OP_LOOKUP)
        begin
            rsp_next.status       = best_hit_reg ? ST_DONE : ST_NOT_FOUND;
            rsp_next.next_hop_out = best_hop_reg;
            rsp_next.iface_out    = best_ifc_reg;
            rsp_next.match_len    = best_len_reg;
        end
        else
        begin
            rsp_next.status = cmd.code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            child_mem[clr_idx_reg] <= '0;
            slot_mem[clr_idx_reg]  <= '0;
        end
        else if (cmd.alloc)
        begin
            child_mem[node_reg] <= alloc_row;
        end
        else if (cmd.slot_wr)
        begin
            slot_mem[node_reg] <= wr_row;
        end
        if (cmd.rd)
        begin
            child_rd_reg <= child_mem[node_reg];
            slot_rd_reg  <= slot_mem[node_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req_word.opcode;
            addr_sh_reg  <= req_word.address;
            q_reg        <= req_word.prefix_len[5:2];
            r_reg        <= req_word.prefix_len[1:0];
            len_bad_reg  <= (req_word.opcode != OP_LOOKUP) && (req_word.prefix_len > 6'd32);
            hop_reg      <= req_word.next_hop_in;
            ifc_reg      <= iface_wrap(req_word.iface_in);
            node_reg     <= '0;
            level_reg    <= '0;
            fresh_reg    <= 1'b0;
            best_hit_reg <= 1'b0;
            best_hop_reg <= '0;
            best_ifc_reg <= '0;
            best_len_reg <= '0;
        end
        else if (cmd.alloc)
        begin
            node_reg    <= niu_reg[NODE_W-1:0];
            level_reg   <= level_reg + 1'b1;
            addr_sh_reg <= addr_sh_reg << STRIDE_BITS;
            fresh_reg   <= 1'b1;
        end
        else if (cmd.descend || (cmd.lk_eval && !stat.lk_stop))
        begin
            node_reg    <= child;
            level_reg   <= level_reg + 1'b1;
            addr_sh_reg <= addr_sh_reg << STRIDE_BITS;
        end
        if (cmd.lk_eval)
        begin
            best_hit_reg <= best_hit_next;
            best_hop_reg <= best_hop_next;
            best_ifc_reg <= best_ifc_next;
            best_len_reg <= best_len_next;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            niu_reg       <= (NODE_W + 1)'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.alloc)
            begin
                niu_reg <= niu_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

@@ sim/multibit_trie_lpm_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// multibit_trie_lpm_table_top_tb
// Drives insert, search, lookup and delete words into the route table and
// compares every response word with a behavioral trie kept in the bench or
// with a typed expectation given for that word.
module multibit_trie_lpm_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtl_pkg::*;

    localparam int NODES      = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_word;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_word;

    multibit_trie_lpm_table_top #(.NODE_COUNT(NODES), .IFACE_COUNT(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
    );

    // Bench copy of the trie.
    int          child_tab [NODES*CHILD_FANOUT];
    bit          route_ok  [NODES*SLOT_FANOUT];
    logic [31:0] route_hop [NODES*SLOT_FANOUT];
    logic [3:0]  route_ifc [NODES*SLOT_FANOUT];
    int          nodes_used;

    rsp_t expected_rsp[$];
    int   errors;
    int   idle_cycles;
    bit   quiet;
    bit   hold_go;
    int   hold_left;
    int   n_lookup_hits;
    int   n_full;
    int   n_words;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int addr_bits(logic [31:0] a, int pos, int n);
        if (n == 0)
            return 0;
        return int'((a >> (32 - pos - n)) & ((32'd1 << n) - 1));
    endfunction

    function automatic rsp_t route_step(req_t w);
        rsp_t o;
        int   node;
        int   pos;
        int   rem;
        int   maxr;
        int   s;
        int   c;
        int   q;
        int   r;
        int   missing;
        int   li;
        bit   found;
        o = '0;
        o.status = ST_NOT_FOUND;
        if (w.opcode == OP_LOOKUP)
        begin
            node = 0;
            pos = 0;
            forever
            begin
                rem = 32 - pos;
                maxr = (rem < 3) ? rem : 3;
                for (int k = 0; k <= maxr; k++)
                begin
                    s = node*SLOT_FANOUT + (1 << k) - 1 + addr_bits(w.address, pos, k);
                    if (route_ok[s])
                    begin
                        o.status = ST_DONE;
                        o.next_hop_out = route_hop[s];
                        o.iface_out = route_ifc[s];
                        o.match_len = 6'(pos + k);
                    end
                end
                if (rem < STRIDE_BITS)
                    break;
                c = child_tab[node*CHILD_FANOUT + addr_bits(w.address, pos, STRIDE_BITS)];
                if (c == 0)
                    break;
                node = c;
                pos += STRIDE_BITS;
            end
        end
        else if (w.prefix_len <= 32)
        begin
            q = w.prefix_len / STRIDE_BITS;
            r = w.prefix_len % STRIDE_BITS;
            node = 0;
            found = 1;
            missing = 0;
            for (int i = 0; i < q; i++)
            begin
                c = child_tab[node*CHILD_FANOUT + addr_bits(w.address, i*STRIDE_BITS, STRIDE_BITS)];
                if (c == 0)
                begin
                    found = 0;
                    missing = q - i;
                    break;
                end
                node = c;
            end
            if (w.opcode == OP_INSERT)
            begin
                if (!found && missing > NODES - nodes_used)
                    o.status = ST_FULL;
                else
                begin
                    node = 0;
                    for (int i = 0; i < q; i++)
                    begin
                        li = node*CHILD_FANOUT + addr_bits(w.address, i*STRIDE_BITS, STRIDE_BITS);
                        if (child_tab[li] == 0)
                        begin
                            child_tab[li] = nodes_used;
                            nodes_used++;
                        end
                        node = child_tab[li];
                    end
                    s = node*SLOT_FANOUT + (1 << r) - 1 + addr_bits(w.address, q*STRIDE_BITS, r);
                    route_ok[s] = 1;
                    route_hop[s] = w.next_hop_in;
                    route_ifc[s] = w.iface_in;
                    o.status = ST_DONE;
                end
            end
            else if (found)
            begin
                s = node*SLOT_FANOUT + (1 << r) - 1 + addr_bits(w.address, q*STRIDE_BITS, r);
                if (route_ok[s])
                begin
                    o.status = ST_DONE;
                    if (w.opcode == OP_DELETE)
                    begin
                        route_ok[s] = 0;
                        route_hop[s] = '0;
                        route_ifc[s] = '0;
                    end
                end
            end
        end
        return o;
    endfunction

    // Offers one word, waits for it to be taken and books the expected response.
    // A typed expectation replaces the computed one when given.
    task automatic send_word(req_t w, bit typed, rsp_t typed_rsp);
        rsp_t e;
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        e = route_step(w);
        expected_rsp.insert(expected_rsp.size(), typed ? typed_rsp : e);
        n_words++;
        if (!quiet && $urandom_range(99) < 21)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
    endtask

    function automatic req_t mk(opcode_t op, logic [31:0] a, int len,
                                logic [31:0] hop, logic [3:0] ifc);
        req_t w;
        w.opcode = op;
        w.address = a;
        w.prefix_len = 6'(len);
        w.next_hop_in = hop;
        w.iface_in = ifc;
        return w;
    endfunction

    function automatic rsp_t mkr(status_t st, logic [31:0] hop, logic [3:0] ifc, int len);
        rsp_t o;
        o.status = st;
        o.next_hop_out = hop;
        o.iface_out = ifc;
        o.match_len = 6'(len);
        return o;
    endfunction

    // Response side: check and random stall, with one long hold-off on request.
    always @(posedge clk)
    begin
        rsp_t e;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp_word.status != e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp_word.status);
                    errors++;
                end
                if (rsp_word.next_hop_out != e.next_hop_out)
                begin
                    $error("next_hop_out exp %h got %h", e.next_hop_out, rsp_word.next_hop_out);
                    errors++;
                end
                if (rsp_word.iface_out != e.iface_out)
                begin
                    $error("iface_out exp %0d got %0d", e.iface_out, rsp_word.iface_out);
                    errors++;
                end
                if (rsp_word.match_len != e.match_len)
                begin
                    $error("match_len exp %0d got %0d", e.match_len, rsp_word.match_len);
                    errors++;
                end
                if (e.status == ST_FULL)
                    n_full++;
                if (e.status == ST_DONE && e.match_len != 0 || e.next_hop_out != 0)
                    n_lookup_hits++;
            end
        end
        if (hold_go && hold_left == 0)
            hold_left = HOLD_LEN;
        if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_go = 0;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= rst_n && !quiet && ($urandom_range(99) < 21);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    typedef struct {
        req_t w;
        bit   typed;
        rsp_t r;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void add_row(req_t w, bit typed, rsp_t r);
        dir_row_t row;
        row.w = w;
        row.typed = typed;
        row.r = r;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    initial
    begin
        logic [31:0] pool_addr[32];
        int          pool_len[32];
        int          p;
        int          sel;
        logic [31:0] a;
        rsp_t        none;
        none = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        rsp_stall = 1'b0;
        quiet = 0;
        hold_go = 0;
        hold_left = 0;
        errors = 0;
        n_words = 0;
        n_full = 0;
        n_lookup_hits = 0;
        foreach (child_tab[i]) child_tab[i] = 0;
        foreach (route_ok[i])
        begin
            route_ok[i] = 0;
            route_hop[i] = '0;
            route_ifc[i] = '0;
        end
        nodes_used = 1;

        add_row(mk(OP_LOOKUP, 32'h0, 0, 0, 0), 1, mkr(ST_NOT_FOUND, 0, 0, 0));
        add_row(mk(OP_SEARCH, 32'h0, 0, 0, 0), 1, mkr(ST_NOT_FOUND, 0, 0, 0));
        add_row(mk(OP_INSERT, 32'hFFFF_FFFF, 63, 32'h1, 1), 1,
                mkr(ST_NOT_FOUND, 0, 0, 0));
        add_row(mk(OP_SEARCH, 32'h0, 33, 0, 0), 1, mkr(ST_NOT_FOUND, 0, 0, 0));
        add_row(mk(OP_DELETE, 32'h1234_5678, 16, 0, 0), 1,
                mkr(ST_NOT_FOUND, 0, 0, 0));
        add_row(mk(OP_INSERT, 32'h0, 0, 32'hFFFF_FFFF, 15), 1,
                mkr(ST_DONE, 0, 0, 0));
        add_row(mk(OP_LOOKUP, 32'hDEAD_BEEF, 0, 0, 0), 1,
                mkr(ST_DONE, 32'hFFFF_FFFF, 15, 0));
        add_row(mk(OP_INSERT, 32'hFFFF_FFFF, 32, 32'hA5A5_5A5A, 9), 1,
                mkr(ST_DONE, 0, 0, 0));
        add_row(mk(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0), 1,
                mkr(ST_DONE, 32'hA5A5_5A5A, 9, 32));
        add_row(mk(OP_LOOKUP, 32'hFFFF_FFFE, 0, 0, 0), 0, none);
        for (int l = 1; l <= 7; l++)
            add_row(mk(OP_INSERT, 32'hC000_0000, l, 32'h100 + l, 4'(l)), 0, none);
        add_row(mk(OP_LOOKUP, 32'hC123_4567, 0, 0, 0), 0, none);
        add_row(mk(OP_INSERT, 32'hC000_0000, 3, 32'h7777, 7), 0, none);
        add_row(mk(OP_SEARCH, 32'hDFFF_FFFF, 3, 0, 0), 0, none);
        add_row(mk(OP_DELETE, 32'hC000_0000, 7, 0, 0), 0, none);
        add_row(mk(OP_DELETE, 32'hC000_0000, 7, 0, 0), 0, none);
        add_row(mk(OP_INSERT, 32'h8765_4321, 31, 32'h5555_AAAA, 6), 0, none);
        add_row(mk(OP_LOOKUP, 32'h8765_4320, 0, 0, 0), 0, none);
        add_row(mk(OP_DELETE, 32'h0, 0, 0, 0), 0, none);
        add_row(mk(OP_LOOKUP, 32'h0000_0001, 0, 0, 0), 0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

        // Random part: traffic around a small set of known prefixes.
        for (int n = 0; n < 1300; n++)
        begin
            if (n % 300 == 0)
                foreach (pool_addr[i])
                begin
                    pool_addr[i] = $urandom;
                    pool_len[i] = ($urandom_range(3) == 0) ? 32 : $urandom_range(24);
                end
            quiet = (n >= 200 && n < 400);
            if (n == 500)
                hold_go = 1;
            p = $urandom_range(31);
            sel = $urandom_range(99);
            a = pool_addr[p] ^ ($urandom >> pool_len[p]);
            if (sel < 35)
                send_word(mk(OP_INSERT, pool_addr[p], pool_len[p], $urandom,
                             4'($urandom_range(15))), 0, none);
            else if (sel < 50)
                send_word(mk(OP_SEARCH, pool_addr[p], pool_len[p], $urandom, 0), 0, none);
            else if (sel < 75)
                send_word(mk(OP_LOOKUP, a, $urandom_range(63), $urandom, 0), 0, none);
            else if (sel < 80)
                send_word(mk(OP_LOOKUP, $urandom, 0, 0, 0), 0, none);
            else if (sel < 95)
                send_word(mk(OP_DELETE, a, pool_len[p], 0, 0), 0, none);
            else
                send_word(mk(opcode_t'($urandom_range(3)), $urandom, $urandom_range(33, 63),
                             $urandom, 4'($urandom_range(15))), 0, none);
        end

        // Fill the node pool with a fixed run of scattered host route inserts.
        for (int n = 0; n < 200; n++)
        begin
            a = $urandom;
            send_word(mk(OP_INSERT, a, 32, $urandom, 4'($urandom_range(15))), 0, none);
            if (n % 4 == 0)
                send_word(mk(OP_LOOKUP, a, 0, 0, 0), 0, none);
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d request words, %0d responses with a route, %0d pool-full refusals",
                 n_words, n_lookup_hits, n_full);
        $display("%0d of %0d trie nodes allocated at the end", nodes_used, NODES);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
